// ===== design/imap_pkg.sv =====
// imap_pkg: shared constants, types and helpers for the injective mapping enumerator
// used by injective_mapping_enumerator, imap_lists and imap_checker; no dependencies
package imap_pkg;

  localparam int MAX_LEN = 16;
  localparam int POS_W   = 16;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT        = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEN_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_SECOND = 2'd1;

  // list select bit in the shared position memory
  localparam logic LIST_FIRST  = 1'b0;
  localparam logic LIST_SECOND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_BT_RD,
    ST_BT_EVAL,
    ST_EM_ASG,
    ST_EM_LIST,
    ST_EM_OUT,
    ST_EXH
  } state_t;

  // request bundle to the position memory
  typedef struct packed {
    logic             we;
    logic [IDX_W:0]   waddr;
    logic [POS_W-1:0] wdata;
    logic             re;
    logic [IDX_W:0]   raddr_a;
    logic [IDX_W:0]   raddr_b;
  } list_req_t;

  // saturate a programmed length into 1..MAX_LEN
  function automatic logic [LEN_W-1:0] sat_len(input logic [CFG_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > MAX_LEN) begin
      r = LEN_W'(MAX_LEN);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

  // lowest free index c with from <= c < n; msb is the found flag
  function automatic logic [IDX_W:0] find_free(input logic [MAX_LEN-1:0] used,
                                               input logic [LEN_W-1:0]   from,
                                               input logic [LEN_W-1:0]   n);
    logic [IDX_W:0] r;
    r = '0;
    for (int c = MAX_LEN - 1; c >= 0; c--) begin
      if (!used[c] && (LEN_W'(c) >= from) && (LEN_W'(c) < n)) begin
        r = {1'b1, IDX_W'(c)};
      end
    end
    return r;
  endfunction

endpackage

// ===== design/imap_lists.sv =====
// imap_lists: position memory holding both lists, one write port, two registered reads
// depends on imap_pkg
module imap_lists import imap_pkg::*; (
  input  logic             clk,
  input  list_req_t        req,
  output logic [POS_W-1:0] rdata_a,
  output logic [POS_W-1:0] rdata_b
);

  logic [POS_W-1:0] mem [2*MAX_LEN];
  logic [POS_W-1:0] rdata_a_r;
  logic [POS_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_a_r <= mem[req.raddr_a];
      rdata_b_r <= mem[req.raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== design/injective_mapping_enumerator.sv =====
// injective_mapping_enumerator: top level, command decode, enumeration sequencer
// depends on imap_pkg and imap_lists
//
// Loads two lists of 16-bit positions (cmd 0 / cmd 1, one entry per request) and on
// each next-mapping request (cmd 2) emits one injective mapping from the shorter list
// (k entries) into the longer one (n entries), in lexicographic order of the index
// tuple, as k results in first/second order with last on the final pair. The request
// after the final mapping emits one exhausted result (zero positions, last and
// exhausted set), and the next request starts over. A load or a write to
// len_first/len_second restarts the enumeration. The current index tuple lives in
// a 16 x 4 assignment memory with a registered read; the used flags of the longer
// list are flip-flops searched by a priority pick. A next request that starts a
// fresh walk fills the tuple entry by entry; one that backtracks reads the
// assignment memory, then releases and re-picks, for each entry it backs over, and
// refills the entries after the re-picked one in turn. Each output pair takes an
// assignment read, a list read and the output register, and output stalls can hold
// it. Loads and configuration writes are taken only between requests.
module injective_mapping_enumerator import imap_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input request channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CMD_W-1:0]     in_cmd,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [POS_W-1:0]     in_position,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [POS_W-1:0]     out_pos_first,
  output logic [POS_W-1:0]     out_pos_second,
  output logic                 out_last,
  output logic                 out_exhausted,
  // configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // sequencer state
  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [MAX_LEN-1:0]   taken_r, taken_nxt;
  logic                 started_r, started_nxt;

  // configuration registers
  logic [CFG_W-1:0]     len_first_r, len_first_nxt;
  logic [CFG_W-1:0]     len_second_r, len_second_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]     out_pos_first_r, out_pos_first_nxt;
  logic [POS_W-1:0]     out_pos_second_r, out_pos_second_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_exhausted_r, out_exhausted_nxt;

  // assignment memory: index into the longer list for each shorter-list entry
  logic [IDX_W-1:0]     asg_mem [MAX_LEN];
  logic [IDX_W-1:0]     asg_rdata_r;
  logic                 asg_we;
  logic [IDX_W-1:0]     asg_wdata;
  logic                 asg_re;

  // position memory
  list_req_t            list_req;
  logic [POS_W-1:0]     list_rdata_a;
  logic [POS_W-1:0]     list_rdata_b;

  // derived lengths
  logic [LEN_W-1:0]     len1_eff;
  logic [LEN_W-1:0]     len2_eff;
  logic                 swapped;
  logic [LEN_W-1:0]     k_len;
  logic [LEN_W-1:0]     n_len;
  logic [IDX_W-1:0]     k_last;
  logic                 at_last;

  // handshakes
  logic                 in_acc;
  logic                 cfg_acc;
  logic                 out_free;
  logic                 is_load;
  logic                 is_next;

  // free-index search
  logic [MAX_LEN-1:0]   taken_clr;
  logic [MAX_LEN-1:0]   search_used;
  logic [LEN_W-1:0]     search_from;
  logic [IDX_W:0]       pick;
  logic                 pick_found;
  logic [IDX_W-1:0]     pick_idx;

  assign len1_eff = sat_len(len_first_r);
  assign len2_eff = sat_len(len_second_r);
  // on a tie the first list is the shorter one
  assign swapped  = len1_eff > len2_eff;
  assign k_len    = swapped ? len2_eff : len1_eff;
  assign n_len    = swapped ? len1_eff : len2_eff;
  assign k_last   = IDX_W'(k_len - LEN_W'(1));
  assign at_last  = (idx_r == k_last);

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign is_load   = (in_cmd == CMD_LOAD_FIRST) || (in_cmd == CMD_LOAD_SECOND);
  assign is_next   = (in_cmd == CMD_NEXT);

  // releasing the current index of this entry before looking past it
  assign taken_clr = taken_r & ~(MAX_LEN'(1) << asg_rdata_r);

  // fill picks from zero over the live flags, backtrack picks above the old index
  always_comb begin
    if (state_r == ST_BT_EVAL) begin
      search_used = taken_clr;
      search_from = LEN_W'({1'b0, asg_rdata_r}) + LEN_W'(1);
    end else begin
      search_used = taken_r;
      search_from = '0;
    end
  end

  assign pick       = find_free(search_used, search_from, n_len);
  assign pick_found = pick[IDX_W];
  assign pick_idx   = pick[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_next) begin
          state_nxt = started_r ? ST_BT_RD : ST_FILL;
        end
      end
      ST_FILL: begin
        if (at_last) begin
          state_nxt = ST_EM_ASG;
        end
      end
      ST_BT_RD: begin
        state_nxt = ST_BT_EVAL;
      end
      ST_BT_EVAL: begin
        if (pick_found) begin
          state_nxt = at_last ? ST_EM_ASG : ST_FILL;
        end else if (idx_r == '0) begin
          state_nxt = ST_EXH;
        end else begin
          state_nxt = ST_BT_RD;
        end
      end
      ST_EM_ASG: begin
        state_nxt = ST_EM_LIST;
      end
      ST_EM_LIST: begin
        state_nxt = ST_EM_OUT;
      end
      ST_EM_OUT: begin
        if (out_free) begin
          state_nxt = at_last ? ST_IDLE : ST_EM_ASG;
        end
      end
      ST_EXH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt            = idx_r;
    taken_nxt          = taken_r;
    started_nxt        = started_r;
    len_first_nxt      = len_first_r;
    len_second_nxt     = len_second_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_pos_first_nxt  = out_pos_first_r;
    out_pos_second_nxt = out_pos_second_r;
    out_last_nxt       = out_last_r;
    out_exhausted_nxt  = out_exhausted_r;
    asg_we             = 1'b0;
    asg_wdata          = pick_idx;
    asg_re             = 1'b0;
    list_req           = '0;
    list_req.waddr     = {(in_cmd == CMD_LOAD_SECOND), in_slot[IDX_W-1:0]};
    list_req.wdata     = in_position;
    list_req.raddr_a   = {swapped ? LIST_SECOND : LIST_FIRST, idx_r};
    list_req.raddr_b   = {swapped ? LIST_FIRST : LIST_SECOND, asg_rdata_r};

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          // a write to either length register restarts; unknown indexes are dropped
          if (cfg_index == REG_LEN_FIRST) begin
            len_first_nxt = cfg_data;
            taken_nxt     = '0;
            started_nxt   = 1'b0;
          end else if (cfg_index == REG_LEN_SECOND) begin
            len_second_nxt = cfg_data;
            taken_nxt      = '0;
            started_nxt    = 1'b0;
          end
        end
        if (in_acc && is_load) begin
          list_req.we = 1'b1;
          taken_nxt   = '0;
          started_nxt = 1'b0;
        end else if (in_acc && is_next) begin
          if (started_r) begin
            // backtrack from the deepest entry
            idx_nxt = k_last;
          end else begin
            taken_nxt = '0;
            idx_nxt   = '0;
          end
        end
      end
      ST_FILL: begin
        // k <= n so a free index always exists here
        asg_we    = 1'b1;
        taken_nxt = taken_r | (MAX_LEN'(1) << pick_idx);
        if (at_last) begin
          started_nxt = 1'b1;
          idx_nxt     = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_BT_RD: begin
        asg_re = 1'b1;
      end
      ST_BT_EVAL: begin
        if (pick_found) begin
          asg_we    = 1'b1;
          taken_nxt = taken_clr | (MAX_LEN'(1) << pick_idx);
          idx_nxt   = at_last ? '0 : idx_r + IDX_W'(1);
        end else if (idx_r == '0) begin
          // enumeration done, next request starts over
          taken_nxt   = '0;
          started_nxt = 1'b0;
        end else begin
          taken_nxt = taken_clr;
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end
      ST_EM_ASG: begin
        asg_re = 1'b1;
      end
      ST_EM_LIST: begin
        list_req.re = 1'b1;
      end
      ST_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_pos_first_nxt  = swapped ? list_rdata_b : list_rdata_a;
          out_pos_second_nxt = swapped ? list_rdata_a : list_rdata_b;
          out_last_nxt       = at_last;
          out_exhausted_nxt  = 1'b0;
          idx_nxt            = idx_r + IDX_W'(1);
        end
      end
      ST_EXH: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_pos_first_nxt  = '0;
          out_pos_second_nxt = '0;
          out_last_nxt       = 1'b1;
          out_exhausted_nxt  = 1'b1;
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      taken_r      <= '0;
      started_r    <= 1'b0;
      len_first_r  <= CFG_W'(1);
      len_second_r <= CFG_W'(1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      taken_r      <= taken_nxt;
      started_r    <= started_nxt;
      len_first_r  <= len_first_nxt;
      len_second_r <= len_second_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_pos_first_r  <= out_pos_first_nxt;
    out_pos_second_r <= out_pos_second_nxt;
    out_last_r       <= out_last_nxt;
    out_exhausted_r  <= out_exhausted_nxt;
  end

  // assignment memory; a write and a read of one entry never share a cycle, the
  // sequencer always reads an entry in a later state than the one that wrote it
  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[idx_r] <= asg_wdata;
    end
    if (asg_re) begin
      asg_rdata_r <= asg_mem[idx_r];
    end
  end

  imap_lists u_lists (
    .clk     (clk),
    .req     (list_req),
    .rdata_a (list_rdata_a),
    .rdata_b (list_rdata_b)
  );

  assign out_valid      = out_valid_r;
  assign out_pos_first  = out_pos_first_r;
  assign out_pos_second = out_pos_second_r;
  assign out_last       = out_last_r;
  assign out_exhausted  = out_exhausted_r;

endmodule

// ===== design/imap_checker.sv =====
// imap_checker: port-level checks of the enumerator's result channel
// depends on imap_pkg; bound to injective_mapping_enumerator
module imap_checker import imap_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [POS_W-1:0] out_pos_first,
  input logic [POS_W-1:0] out_pos_second,
  input logic             out_last,
  input logic             out_exhausted
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_first) &&
      $stable(out_pos_second) && $stable(out_last) && $stable(out_exhausted))
    else $error("result changed while stalled");

  // exhausted result is also marked last
  a_exh_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_last)
    else $error("exhausted result without last");

  // exhausted result carries zero positions
  a_exh_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_exhausted |-> out_pos_first == '0 && out_pos_second == '0)
    else $error("exhausted result with nonzero positions");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind injective_mapping_enumerator imap_checker u_imap_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pos_first  (out_pos_first),
  .out_pos_second (out_pos_second),
  .out_last       (out_last),
  .out_exhausted  (out_exhausted)
);

// ===== tb/sv/tb_injective_mapping_enumerator.sv =====
// tb_injective_mapping_enumerator: self-checking testbench for the injective mapping enumerator
// drives list loads, next-mapping requests, length writes; checks pairs against table or predictor
// depends on imap_pkg and injective_mapping_enumerator
module tb_injective_mapping_enumerator;
  import imap_pkg::*;

  // command code the block leaves unused, and register indexes it does not decode
  localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  // time for the worst next request to finish before touching registers
  localparam int unsigned DRAIN_CYCLES   = 6 * MAX_LEN + 4;
  localparam int unsigned SETTLE_LIMIT   = 50000;
  localparam int unsigned REQUEST_TARGET = 300;
  localparam int unsigned SWEEP_COUNT    = 10;

  typedef struct packed {
    logic [POS_W-1:0] pos_first;
    logic [POS_W-1:0] pos_second;
    logic             last;
    logic             exhausted;
  } pair_t;

  // one row of the directed table; typed rows carry their single expected pair
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic              typed;
    pair_t             want;
  } dir_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_COIN,
    STALL_EVERY4,
    STALL_RARE
  } stall_mode_t;

  localparam pair_t NO_PAIR  = '0;
  localparam pair_t EXH_PAIR = '{16'h0000, 16'h0000, 1'b1, 1'b1};

  // lengths stay at their reset value of 1 here, so every mapping is a single pair
  localparam dir_row_t DIRECTED [21] = '{
    '{CMD_LOAD_FIRST,  4'd0,  16'hFFFF, 1'b0, NO_PAIR},
    '{CMD_LOAD_SECOND, 4'd0,  16'h0000, 1'b0, NO_PAIR},
    // first mapping right after reset
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, '{16'hFFFF, 16'h0000, 1'b1, 1'b0}},
    // only one mapping exists, so the walk runs out
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, EXH_PAIR},
    // and starts over
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, '{16'hFFFF, 16'h0000, 1'b1, 1'b0}},
    // unused command: no result and the walk stays where it is
    '{CMD_UNUSED,      4'd15, 16'hABCD, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, EXH_PAIR},
    '{CMD_LOAD_SECOND, 4'd0,  16'hFFFF, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}},
    // a load beyond the active length still restarts the walk
    '{CMD_LOAD_FIRST,  4'd15, 16'h0000, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, '{16'hFFFF, 16'hFFFF, 1'b1, 1'b0}},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, EXH_PAIR},
    '{CMD_LOAD_SECOND, 4'd15, 16'hFFFF, 1'b0, NO_PAIR},
    '{CMD_LOAD_FIRST,  4'd0,  16'h0000, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, '{16'h0000, 16'hFFFF, 1'b1, 1'b0}},
    '{CMD_LOAD_FIRST,  4'd7,  16'h5A5A, 1'b0, NO_PAIR},
    '{CMD_LOAD_SECOND, 4'd8,  16'hA5A5, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b1, EXH_PAIR},
    '{CMD_UNUSED,      4'd0,  16'h0000, 1'b0, NO_PAIR},
    '{CMD_NEXT,        4'd0,  16'h0000, 1'b0, NO_PAIR}
  };

  // length sweep run after the directed table: ties, swaps, saturation at both ends, full size
  localparam logic [CFG_W-1:0] SWEEP_FIRST  [SWEEP_COUNT] =
    '{5'd2, 5'd3, 5'd3, 5'd0, 5'd4, 5'd16, 5'd1, 5'd16, 5'd31, 5'd5};
  localparam logic [CFG_W-1:0] SWEEP_SECOND [SWEEP_COUNT] =
    '{5'd3, 5'd2, 5'd3, 5'd4, 5'd31, 5'd1, 5'd16, 5'd16, 5'd0, 5'd17};

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     in_cmd;
  logic [SLOT_W-1:0]    in_slot;
  logic [POS_W-1:0]     in_position;
  logic                 out_valid;
  logic                 out_ready;
  logic [POS_W-1:0]     out_pos_first;
  logic [POS_W-1:0]     out_pos_second;
  logic                 out_last;
  logic                 out_exhausted;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // predictor state: list contents, current index tuple, used flags of the longer list
  logic [POS_W-1:0]   first_slots  [MAX_LEN];
  logic [POS_W-1:0]   second_slots [MAX_LEN];
  int unsigned        target_of    [MAX_LEN];
  logic [MAX_LEN-1:0] target_used;
  logic               walk_live;
  logic [CFG_W-1:0]   len_first_q;
  logic [CFG_W-1:0]   len_second_q;

  // which list entries hold a loaded value; nothing unloaded is ever read
  logic [MAX_LEN-1:0] first_loaded;
  logic [MAX_LEN-1:0] second_loaded;

  pair_t       fresh_pairs [$];
  pair_t       pending_pairs [$];
  int unsigned burst_left;
  int unsigned mismatches;
  int unsigned pairs_seen;
  int unsigned exhausted_seen;
  int unsigned requests_sent;
  int unsigned settings_run;

  injective_mapping_enumerator u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_slot        (in_slot),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pos_first  (out_pos_first),
    .out_pos_second (out_pos_second),
    .out_last       (out_last),
    .out_exhausted  (out_exhausted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // programmed length folded into 1..MAX_LEN
  function automatic int unsigned clamp_len(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_LEN) return MAX_LEN;
    return int'(v);
  endfunction

  // back to the first mapping: nothing assigned, nothing used
  function automatic void reset_walk();
    for (int i = 0; i < MAX_LEN; i++) begin
      target_of[i] = MAX_LEN;
    end
    target_used = '0;
    walk_live = 1'b0;
  endfunction

  // take the lowest unused longer-list index at or above from; MAX_LEN when none is left
  function automatic int unsigned claim_lowest(input int unsigned from, input int unsigned n);
    for (int unsigned c = from; c < n; c++) begin
      if (!target_used[c]) begin
        target_used[c] = 1'b1;
        return c;
      end
    end
    return MAX_LEN;
  endfunction

  function automatic void fill_targets(input int unsigned start, input int unsigned k,
                                       input int unsigned n);
    for (int unsigned i = start; i < k; i++) begin
      target_of[i] = claim_lowest(0, n);
    end
  endfunction

  // lexicographic successor of the index tuple; 0 once the walk is over
  function automatic logic next_tuple(input int unsigned k, input int unsigned n);
    int unsigned cur;
    int unsigned nxt;
    if (!walk_live) begin
      reset_walk();
      fill_targets(0, k, n);
      walk_live = 1'b1;
      return 1'b1;
    end
    // back off from the rightmost entry until one can move up
    for (int j = int'(k); j > 0; j--) begin
      cur = target_of[j-1];
      if (cur < MAX_LEN) begin
        target_used[cur] = 1'b0;
        nxt = claim_lowest(cur + 1, n);
      end else begin
        nxt = MAX_LEN;
      end
      target_of[j-1] = nxt;
      if (nxt < MAX_LEN) begin
        fill_targets(j, k, n);
        return 1'b1;
      end
    end
    reset_walk();
    return 1'b0;
  endfunction

  // pairs caused by one request, left in fresh_pairs
  function automatic void enumerate_request(input logic [CMD_W-1:0] cmd,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic [POS_W-1:0] pos);
    int unsigned l1;
    int unsigned l2;
    int unsigned k;
    int unsigned n;
    int unsigned other;
    logic        swapped;
    pair_t       p;
    fresh_pairs.delete();
    case (cmd)
      CMD_LOAD_FIRST: begin
        first_slots[slot] = pos;
        reset_walk();
      end
      CMD_LOAD_SECOND: begin
        second_slots[slot] = pos;
        reset_walk();
      end
      CMD_NEXT: begin
        l1 = clamp_len(len_first_q);
        l2 = clamp_len(len_second_q);
        // on a tie the first list is the shorter one
        swapped = (l1 > l2);
        k = swapped ? l2 : l1;
        n = swapped ? l1 : l2;
        if (!next_tuple(k, n)) begin
          fresh_pairs.insert(fresh_pairs.size(), EXH_PAIR);
        end else begin
          for (int unsigned i = 0; i < k; i++) begin
            other = (target_of[i] < MAX_LEN) ? target_of[i] : 0;
            p.pos_first  = swapped ? first_slots[other] : first_slots[i];
            p.pos_second = swapped ? second_slots[i] : second_slots[other];
            p.last       = (i + 1 == k);
            p.exhausted  = 1'b0;
            fresh_pairs.insert(fresh_pairs.size(), p);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one request on the input channel; bursts of random length, random gaps between them
  task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                          input logic [POS_W-1:0] pos, input logic typed, input pair_t want);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid    = 1'b1;
    in_cmd      = cmd;
    in_slot     = slot;
    in_position = pos;
    do @(posedge clk); while (!in_ready);
    // accepted: predict, then queue either the typed pair or the predicted ones
    enumerate_request(cmd, slot, pos);
    if (typed) begin
      pending_pairs.insert(pending_pairs.size(), want);
    end else begin
      foreach (fresh_pairs[i]) pending_pairs.insert(pending_pairs.size(), fresh_pairs[i]);
    end
    if (cmd == CMD_LOAD_FIRST) first_loaded[slot] = 1'b1;
    if (cmd == CMD_LOAD_SECOND) second_loaded[slot] = 1'b1;
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // register write; the caller lowers cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LEN_FIRST: begin
        len_first_q = val;
        reset_walk();
      end
      REG_LEN_SECOND: begin
        len_second_q = val;
        reset_walk();
      end
      default: begin
      end
    endcase
  endtask

  // stop sending, let every expected pair drain, then give the block time to go idle
  task automatic settle();
    int unsigned waited;
    waited = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pairs.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CFG_W-1:0] random_len();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    // mostly short lists so the walk reaches its end, sometimes long or out of range
    if (roll < 7) return CFG_W'($urandom_range(1, 4));
    if (roll < 8) return CFG_W'($urandom_range(5, 16));
    return CFG_W'($urandom_range(0, 31));
  endfunction

  // one length setting: program it, fill any entries it needs, then walk the mappings
  task automatic run_phase(input logic [CFG_W-1:0] lf, input logic [CFG_W-1:0] ls,
                           input logic spare, input logic [CFG_IDX_W-1:0] spare_idx);
    int unsigned k;
    int unsigned n;
    int unsigned total;
    int unsigned nexts;
    int unsigned roll;
    logic        noisy;
    settle();
    if (spare) write_reg(spare_idx, CFG_W'($urandom_range(0, 31)));
    write_reg(REG_LEN_FIRST, lf);
    write_reg(REG_LEN_SECOND, ls);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings_run++;

    // every entry inside the active lengths gets a value before any mapping reads it
    for (int i = 0; i < MAX_LEN; i++) begin
      if (i < int'(clamp_len(lf)) && !first_loaded[i])
        send_req(CMD_LOAD_FIRST, SLOT_W'(i), POS_W'($urandom), 1'b0, NO_PAIR);
      if (i < int'(clamp_len(ls)) && !second_loaded[i])
        send_req(CMD_LOAD_SECOND, SLOT_W'(i), POS_W'($urandom), 1'b0, NO_PAIR);
    end

    // number of mappings, capped: small walks are run to the end and past it
    k = (clamp_len(lf) < clamp_len(ls)) ? clamp_len(lf) : clamp_len(ls);
    n = (clamp_len(lf) < clamp_len(ls)) ? clamp_len(ls) : clamp_len(lf);
    total = 1;
    for (int unsigned i = 0; i < k && total <= 60; i++) begin
      total = total * (n - i);
    end
    if (total <= 60) nexts = total + 1 + $urandom_range(0, 3);
    else if (k >= 8) nexts = $urandom_range(3, 6);
    else nexts = $urandom_range(8, 20);

    // most phases are clean walks; some get loads thrown in that restart the walk
    noisy = ($urandom_range(0, 3) == 0);
    for (int unsigned s = 0; s < nexts; s++) begin
      roll = $urandom_range(0, 19);
      if (noisy && roll < 4) begin
        send_req($urandom_range(0, 1) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST,
                 SLOT_W'($urandom_range(0, 15)), POS_W'($urandom), 1'b0, NO_PAIR);
      end else if (roll == 19) begin
        send_req(CMD_UNUSED, SLOT_W'($urandom), POS_W'($urandom), 1'b0, NO_PAIR);
      end
      send_req(CMD_NEXT, SLOT_W'($urandom), POS_W'($urandom), 1'b0, NO_PAIR);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall patterns and checking
  // ---------------------------------------------------------------------------

  // receiver switches between stall patterns, including long stretches with none
  initial begin : result_backpressure
    stall_mode_t mode;
    int unsigned span;
    out_ready = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (int unsigned tick = 0; tick < span; tick++) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:   out_ready = 1'b1;
          STALL_COIN:   out_ready = 1'($urandom_range(0, 1));
          STALL_EVERY4: out_ready = (tick % 4 == 3);
          default:      out_ready = ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // every accepted pair against the oldest expectation
  always @(posedge clk) begin : result_check
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      pairs_seen++;
      if (out_exhausted) exhausted_seen++;
      if (pending_pairs.size() == 0) begin
        report_mismatch($sformatf("unexpected pair first=%h second=%h last=%b exhausted=%b",
                                  out_pos_first, out_pos_second, out_last, out_exhausted));
      end else begin
        want = pending_pairs.pop_front();
        if (out_pos_first !== want.pos_first || out_pos_second !== want.pos_second ||
            out_last !== want.last || out_exhausted !== want.exhausted) begin
          report_mismatch($sformatf(
            "expected first=%h second=%h last=%b exhausted=%b, got %h %h %b %b",
            want.pos_first, want.pos_second, want.last, want.exhausted,
            out_pos_first, out_pos_second, out_last, out_exhausted));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    pair_t lost;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_LOAD_FIRST;
    in_slot     = '0;
    in_position = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_LEN_FIRST;
    cfg_data    = '0;

    // predictor starts from the reset state: lengths 1, nothing assigned
    for (int i = 0; i < MAX_LEN; i++) begin
      first_slots[i]  = '0;
      second_slots[i] = '0;
    end
    len_first_q    = CFG_W'(1);
    len_second_q   = CFG_W'(1);
    first_loaded   = '0;
    second_loaded  = '0;
    burst_left     = 0;
    mismatches     = 0;
    pairs_seen     = 0;
    exhausted_seen = 0;
    requests_sent  = 0;
    settings_run   = 1;
    reset_walk();

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // directed table at reset lengths
    foreach (DIRECTED[r]) begin
      send_req(DIRECTED[r].cmd, DIRECTED[r].slot, DIRECTED[r].pos,
               DIRECTED[r].typed, DIRECTED[r].want);
    end

    // fixed length sweep, with both undecoded register indexes written along the way
    for (int p = 0; p < SWEEP_COUNT; p++) begin
      run_phase(SWEEP_FIRST[p], SWEEP_SECOND[p], (p == 3 || p == 7),
                (p == 3) ? REG_SPARE_LO : REG_SPARE_HI);
    end

    // random length settings until enough requests went in
    while (requests_sent < REQUEST_TARGET) begin
      run_phase(random_len(), random_len(), ($urandom_range(0, 4) == 0),
                $urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO);
    end

    settle();
    while (pending_pairs.size() != 0) begin
      lost = pending_pairs.pop_front();
      report_mismatch($sformatf("pair first=%h second=%h last=%b exhausted=%b never arrived",
                                lost.pos_first, lost.pos_second, lost.last, lost.exhausted));
    end

    $display("%0d requests over %0d length settings, %0d pairs checked (%0d exhausted)",
             requests_sent, settings_run, pairs_seen, exhausted_seen);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("timeout with %0d pairs still expected", pending_pairs.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/imap_pkg.sv
design/imap_lists.sv
design/injective_mapping_enumerator.sv
design/imap_checker.sv
tb/sv/tb_injective_mapping_enumerator.sv
